[sv/cfsf_pkg.sv]
// Package: shared types, codes and constants of the cascaded FIR section filter.
`default_nettype none

package cfsf_pkg;

    localparam int NUM_SECTIONS_DEF = 32;
    localparam int TAPS             = 3;

    localparam logic signed [15:0] GAIN_RESET     = 16'sd4096;
    localparam logic        [5:0]  SECTIONS_RESET = 6'd32;

    localparam logic REQ_FILTER = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    localparam logic CFG_GAIN     = 1'b0;
    localparam logic CFG_SECTIONS = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] sample_in;
        logic        [6:0]  coef_index;
        logic signed [15:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
    } t_mac_ctl;

endpackage

`default_nettype wire

[sv/cfsf_mac.sv]
// Shared multiply-accumulate unit with rounding and saturation for sections and output gain.
`default_nettype none

module cfsf_mac (
    input  wire                     i_clk,
    input  cfsf_pkg::t_mac_ctl      i_ctl,
    input  wire logic signed [23:0] i_a,
    input  wire logic signed [15:0] i_b,
    output logic signed [23:0]      o_sec,
    output logic                    o_sec_clip,
    output logic signed [15:0]      o_out,
    output logic                    o_out_clip
);

    localparam logic signed [41:0] SEC_RND = 42'sd8192;
    localparam logic signed [40:0] OUT_RND = 41'sd2048;
    localparam logic signed [27:0] SEC_MAX = 28'sd8388607;
    localparam logic signed [27:0] SEC_MIN = -28'sd8388608;
    localparam logic signed [28:0] OUT_MAX = 29'sd32767;
    localparam logic signed [28:0] OUT_MIN = -29'sd32768;

    logic signed [39:0] r_prod;
    logic signed [41:0] r_acc;
    logic signed [39:0] w_mul;
    logic signed [41:0] w_sum;
    logic signed [27:0] w_sec_sh;
    logic signed [40:0] w_out_rnd;
    logic signed [28:0] w_out_sh;

    assign w_mul = 40'(i_a) * 40'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_mul;
        end
        if (i_ctl.acc_load) begin
            r_acc <= 42'(r_prod) + SEC_RND;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + 42'(r_prod);
        end
    end

    assign w_sum     = r_acc + 42'(r_prod);
    assign w_sec_sh  = w_sum[41:14];
    assign w_out_rnd = 41'(r_prod) + OUT_RND;
    assign w_out_sh  = w_out_rnd[40:12];

    always_comb begin
        if (w_sec_sh > SEC_MAX) begin
            o_sec      = 24'(SEC_MAX);
            o_sec_clip = 1'b1;
        end else if (w_sec_sh < SEC_MIN) begin
            o_sec      = 24'(SEC_MIN);
            o_sec_clip = 1'b1;
        end else begin
            o_sec      = 24'(w_sec_sh);
            o_sec_clip = 1'b0;
        end
        if (w_out_sh > OUT_MAX) begin
            o_out      = 16'(OUT_MAX);
            o_out_clip = 1'b1;
        end else if (w_out_sh < OUT_MIN) begin
            o_out      = 16'(OUT_MIN);
            o_out_clip = 1'b1;
        end else begin
            o_out      = 16'(w_out_sh);
            o_out_clip = 1'b0;
        end
    end

endmodule

`default_nettype wire

[sv/cfsf_core.sv]
// Sequencer, coefficient and history memories driving the shared MAC unit.
`default_nettype none

module cfsf_core #(
    parameter int NUM_SECTIONS = cfsf_pkg::NUM_SECTIONS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire                     i_cwr,
    input  cfsf_pkg::t_in_item      i_item,
    input  wire logic signed [15:0] i_gain,
    input  wire logic [5:0]         i_sections,
    input  wire                     i_take,
    output logic                    o_idle,
    output logic                    o_done,
    output cfsf_pkg::t_out_item     o_result
);

    localparam int NCOEF = cfsf_pkg::TAPS * NUM_SECTIONS;
    localparam int CAW   = $clog2(NCOEF);
    localparam int CBW   = $clog2(NCOEF + cfsf_pkg::TAPS);
    localparam int SIW   = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int SCW   = $clog2(NUM_SECTIONS + 1);

    localparam logic [1:0] PH_TAP2 = 2'd0;
    localparam logic [1:0] PH_TAP1 = 2'd1;
    localparam logic [1:0] PH_TAP0 = 2'd2;

    typedef enum logic [5:0] {
        ST_CLR  = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_PRE  = 6'b000100,
        ST_RUN  = 6'b001000,
        ST_GAIN = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state n_state;
    t_state r_state;

    logic        [CAW-1:0] r_clr;
    logic        [SCW-1:0] r_sec;
    logic        [1:0]     r_ph;
    logic        [CBW-1:0] r_base;
    logic        [SCW-1:0] r_use;
    logic                  r_flag;
    logic signed [15:0]    r_x;
    logic signed [15:0]    r_ih0;
    logic signed [15:0]    r_ih1;
    logic signed [23:0]    r_y;
    logic signed [23:0]    r_last;
    logic signed [15:0]    r_cd;
    logic signed [23:0]    r_hd0;
    logic signed [23:0]    r_hd1;

    logic signed [15:0]    m_coef [NCOEF];
    logic signed [23:0]    m_h0   [NUM_SECTIONS];
    logic signed [23:0]    m_h1   [NUM_SECTIONS];

    cfsf_pkg::t_mac_ctl    w_ctl;
    logic signed [23:0]    w_a;
    logic signed [15:0]    w_b;
    logic signed [23:0]    w_sec;
    logic                  w_sec_clip;
    logic signed [15:0]    w_out;
    logic                  w_out_clip;

    logic                  w_run;
    logic                  w_first;
    logic                  w_sec_act;
    logic                  w_fin;
    logic        [SCW-1:0] w_use;
    logic                  w_crd_en;
    logic        [CAW-1:0] w_crd_addr;
    logic                  w_cwe;
    logic        [CAW-1:0] w_cwa;
    logic signed [15:0]    w_cwd;
    logic                  w_hwe;
    logic        [SIW-1:0] w_hwa;
    logic signed [23:0]    w_hwd0;
    logic signed [23:0]    w_hwd1;
    logic                  w_hrd_en;

    assign w_run     = (r_state == ST_RUN);
    assign w_first   = (r_sec == '0);
    assign w_sec_act = (32'(r_sec) < NUM_SECTIONS);
    assign w_fin     = w_run && (r_ph == PH_TAP2) && !w_first;
    assign w_hrd_en  = w_run && (r_ph == PH_TAP1);

    always_comb begin
        if (i_sections == '0) begin
            w_use = SCW'(1);
        end else if (32'(i_sections) > NUM_SECTIONS) begin
            w_use = SCW'(NUM_SECTIONS);
        end else begin
            w_use = SCW'(i_sections);
        end
    end

    always_comb begin
        w_ctl.mul_en   = (w_run && w_sec_act) || (r_state == ST_GAIN);
        w_ctl.acc_load = w_run && (r_ph == PH_TAP1);
        w_ctl.acc_add  = w_run && (r_ph == PH_TAP0);
        w_b            = (r_state == ST_GAIN) ? i_gain : r_cd;
        if (r_state == ST_GAIN) begin
            w_a = r_last;
        end else begin
            case (r_ph)
                PH_TAP2: w_a = w_first ? 24'(r_ih1) : r_hd1;
                PH_TAP1: w_a = w_first ? 24'(r_ih0) : r_hd0;
                PH_TAP0: w_a = w_first ? 24'(r_x) : r_y;
                default: w_a = '0;
            endcase
        end
    end

    cfsf_mac u_mac (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_a        (w_a),
        .i_b        (w_b),
        .o_sec      (w_sec),
        .o_sec_clip (w_sec_clip),
        .o_out      (w_out),
        .o_out_clip (w_out_clip)
    );

    always_comb begin
        w_crd_en   = 1'b0;
        w_crd_addr = '0;
        if (r_state == ST_PRE) begin
            w_crd_en   = 1'b1;
            w_crd_addr = CAW'(cfsf_pkg::TAPS - 1);
        end else if (w_run) begin
            case (r_ph)
                PH_TAP2: begin
                    w_crd_en   = w_sec_act;
                    w_crd_addr = CAW'(r_base + CBW'(1));
                end
                PH_TAP1: begin
                    w_crd_en   = 1'b1;
                    w_crd_addr = CAW'(r_base);
                end
                PH_TAP0: begin
                    w_crd_en   = (32'(r_sec) < NUM_SECTIONS - 1);
                    w_crd_addr = CAW'(r_base + CBW'(2 * cfsf_pkg::TAPS - 1));
                end
                default: begin
                    w_crd_en   = 1'b0;
                    w_crd_addr = '0;
                end
            endcase
        end
    end

    always_comb begin
        w_cwe = 1'b0;
        w_cwa = r_clr;
        w_cwd = '0;
        if (r_state == ST_CLR) begin
            w_cwe = 1'b1;
        end else if ((r_state == ST_IDLE) && i_cwr &&
                     (32'(i_item.coef_index) < NCOEF)) begin
            w_cwe = 1'b1;
            w_cwa = CAW'(i_item.coef_index);
            w_cwd = i_item.coef_value;
        end
    end

    always_comb begin
        w_hwe  = 1'b0;
        w_hwa  = SIW'(r_clr);
        w_hwd0 = '0;
        w_hwd1 = '0;
        if (r_state == ST_CLR) begin
            w_hwe = (32'(r_clr) < NUM_SECTIONS);
        end else if (w_fin) begin
            w_hwe  = 1'b1;
            w_hwa  = SIW'(r_sec - SCW'(1));
            w_hwd0 = w_sec;
            w_hwd1 = r_hd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cwe) begin
            m_coef[w_cwa] <= w_cwd;
        end
        if (w_crd_en) begin
            r_cd <= m_coef[w_crd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            m_h0[w_hwa] <= w_hwd0;
            m_h1[w_hwa] <= w_hwd1;
        end
        if (w_hrd_en) begin
            r_hd0 <= m_h0[SIW'(r_sec)];
            r_hd1 <= m_h1[SIW'(r_sec)];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR:  if (r_clr == CAW'(NCOEF - 1)) n_state = ST_IDLE;
            ST_IDLE: if (i_start) n_state = ST_PRE;
            ST_PRE:  n_state = ST_RUN;
            ST_RUN:  if ((r_ph == PH_TAP2) && !w_sec_act) n_state = ST_GAIN;
            ST_GAIN: n_state = ST_DONE;
            ST_DONE: if (i_take) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_sec   <= '0;
            r_ph    <= PH_TAP2;
            r_base  <= '0;
            r_flag  <= 1'b0;
            r_ih0   <= '0;
            r_ih1   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + CAW'(1);
                end
                ST_IDLE: begin
                    r_sec  <= '0;
                    r_ph   <= PH_TAP2;
                    r_base <= '0;
                    if (i_start) begin
                        r_flag <= 1'b0;
                    end
                end
                ST_RUN: begin
                    case (r_ph)
                        PH_TAP2: r_ph <= PH_TAP1;
                        PH_TAP1: r_ph <= PH_TAP0;
                        PH_TAP0: begin
                            r_ph   <= PH_TAP2;
                            r_sec  <= r_sec + SCW'(1);
                            r_base <= r_base + CBW'(cfsf_pkg::TAPS);
                        end
                        default: r_ph <= PH_TAP2;
                    endcase
                    if (w_fin && (r_sec <= r_use) && w_sec_clip) begin
                        r_flag <= 1'b1;
                    end
                end
                ST_GAIN: begin
                    r_ih1 <= r_ih0;
                    r_ih0 <= r_x;
                end
                default: begin
                    r_clr <= r_clr;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_start) begin
            r_x   <= i_item.sample_in;
            r_use <= w_use;
        end
        if (w_fin) begin
            r_y <= w_sec;
            if (r_sec == r_use) begin
                r_last <= w_sec;
            end
        end
    end

    assign o_idle              = (r_state == ST_IDLE);
    assign o_done              = (r_state == ST_DONE);
    assign o_result.sample_out = w_out;
    assign o_result.saturated  = r_flag | w_out_clip;

endmodule

`default_nettype wire

[sv/cascaded_fir_section_filter_top.sv]
// Top level: cascaded three-tap FIR section filter with config registers and output register.
//
// Input channel (i_in_valid / o_in_stall) carries one request per beat: a
// filter request (one audio sample) or a coefficient write (slot and value).
// A coefficient write gives no result. A filter request runs through every
// section on one shared 24x16 multiply-accumulate unit, three products per
// section, then one product for the output gain; a new sample is not taken
// until the last is through. o_in_stall is high while a sample is in work.
// Output channel (o_out_valid / i_out_stall) delivers one beat per filter
// request from an output register; a waiting beat holds while i_out_stall is
// high, and the next sample may be taken and worked on meanwhile, holding
// at its end until the register frees.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) land at once: index
// 0 is the Q4.12 gain, index 1 the number of sections in use.
// Reset is synchronous: after it the block sweeps the coefficient and
// section history memories to zero with the input stalled; config registers
// return to gain 1.0 and 32 sections.
`default_nettype none

module cascaded_fir_section_filter_top #(
    parameter int NUM_SECTIONS = cfsf_pkg::NUM_SECTIONS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  cfsf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output cfsf_pkg::t_out_item o_out_data,
    input  wire                 i_cfg_we,
    input  wire logic [0:0]     i_cfg_idx,
    input  wire logic [15:0]    i_cfg_data
);

    logic signed [15:0]  r_gain;
    logic        [5:0]   r_sections;
    logic                r_out_valid;
    cfsf_pkg::t_out_item r_out_data;

    logic                w_idle;
    logic                w_done;
    logic                w_accept;
    logic                w_start;
    logic                w_cwr;
    logic                w_take;
    cfsf_pkg::t_out_item w_result;

    assign w_accept = i_in_valid && w_idle;
    assign w_start  = w_accept && (i_in_data.req_type == cfsf_pkg::REQ_FILTER);
    assign w_cwr    = w_accept && (i_in_data.req_type == cfsf_pkg::REQ_COEF);
    assign w_take   = w_done && (!r_out_valid || !i_out_stall);

    cfsf_core #(
        .NUM_SECTIONS (NUM_SECTIONS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_cwr      (w_cwr),
        .i_item     (i_in_data),
        .i_gain     (r_gain),
        .i_sections (r_sections),
        .i_take     (w_take),
        .o_idle     (w_idle),
        .o_done     (w_done),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= cfsf_pkg::GAIN_RESET;
            r_sections <= cfsf_pkg::SECTIONS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cfsf_pkg::CFG_GAIN:     r_gain     <= i_cfg_data;
                cfsf_pkg::CFG_SECTIONS: r_sections <= i_cfg_data[5:0];
                default:                r_gain     <= r_gain;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= w_result;
        end
    end

    assign o_in_stall  = !w_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
